// File: rtl/core/ssw_pkg.sv
// Shared types, constants and text tables for the seven-segment weight formatter.
`timescale 1ns / 1ps
`default_nettype none
package ssw_pkg;

   localparam int NUM_DIGITS = 8;
   localparam int IDX_W      = $clog2(NUM_DIGITS);
   localparam int TEXT_LEN   = 8;

   // Rounding to tenths of a gram: (mag + 50) / 100 via reciprocal multiply.
   localparam logic [31:0] ROUND_HALF  = 32'd50;
   localparam logic [31:0] RECIP_100   = 32'd1374389535;
   localparam int          RECIP_SHIFT = 37;
   localparam int          PROD_W      = 64;
   localparam int          QUOT_W      = PROD_W - RECIP_SHIFT;

   // Pipelined shift-and-add-3 conversion.
   localparam int BCD_DIGITS = 8;
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int DD_STAGES  = 4;
   localparam int DD_STEPS   = 7;
   localparam int BIN_W      = DD_STAGES * DD_STEPS;

   localparam logic [31:0] MOST_NEG = 32'h8000_0000;
   localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;

   localparam logic [6:0] CH_SPACE = 7'd32;
   localparam logic [6:0] CH_MINUS = 7'd45;
   localparam logic [6:0] CH_DOT   = 7'd46;
   localparam logic [6:0] CH_ZERO  = 7'd48;

   typedef enum logic [3:0] {
      MODE_WEIGHT     = 4'd0,
      MODE_SETPOINT   = 4'd1,
      MODE_ERROR      = 4'd2,
      MODE_CAL_ZERO   = 4'd3,
      MODE_CAL_SPAN   = 4'd4,
      MODE_DONE       = 4'd5,
      MODE_HOLD       = 4'd6,
      MODE_STARTUP    = 4'd7,
      MODE_CONNECTING = 4'd8,
      MODE_CONNECTED  = 4'd9
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       neg;
      logic       stable;
      logic [3:0] attempt;
   } side_type;

   typedef struct packed {
      logic [BCD_W-1:0] bcd;
      logic [BIN_W-1:0] bin;
   } dd_type;

   typedef struct packed {
      logic [NUM_DIGITS-1:0][6:0] chars;
      logic [NUM_DIGITS-1:0]      dps;
   } screen_type;

   // Fixed text of each mode, leftmost character in the top byte.
   function automatic logic [8*TEXT_LEN-1:0] text_screen(input mode_type m);
      logic [8*TEXT_LEN-1:0] s;
      case (m)
         MODE_SETPOINT:   s = "SP      ";
         MODE_ERROR:      s = "Err     ";
         MODE_CAL_ZERO:   s = "CAL0    ";
         MODE_CAL_SPAN:   s = "SPAn    ";
         MODE_DONE:       s = "donE    ";
         MODE_HOLD:       s = "HoLd    ";
         MODE_STARTUP:    s = "Coffee  ";
         MODE_CONNECTING: s = "Air     ";
         MODE_CONNECTED:  s = "ConnECtd";
         default:         s = "        ";
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ssw_round.sv
// Two-stage magnitude, rounding offset and divide-by-100 by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none
module ssw_round
   import ssw_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_stall,
   input  wire logic signed [31:0] in_weight_mg,
   input  wire side_type           in_side,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output logic [BIN_W-1:0]        out_tenths,
   output side_type                out_side
);

   logic             a_valid_ff, a_valid_in;
   logic [31:0]      a_sum_ff;
   side_type         a_side_ff;
   logic             b_valid_ff, b_valid_in;
   logic [PROD_W-1:0] b_prod_ff;
   side_type         b_side_ff;
   logic             adv_a, adv_b;
   logic [31:0]      raw, mag;

   always_comb begin
      raw = 32'(in_weight_mg);
      if (raw == MOST_NEG) begin
         mag = MOST_POS;
      end else if (raw[31]) begin
         mag = 32'd0 - raw;
      end else begin
         mag = raw;
      end
      adv_b      = !b_valid_ff || !out_stall;
      adv_a      = !a_valid_ff || adv_b;
      a_valid_in = adv_a ? in_valid : a_valid_ff;
      b_valid_in = adv_b ? a_valid_ff : b_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a && in_valid) begin
         a_sum_ff  <= mag + ROUND_HALF;
         a_side_ff <= in_side;
      end
      if (adv_b && a_valid_ff) begin
         b_prod_ff <= PROD_W'(a_sum_ff) * PROD_W'(RECIP_100);
         b_side_ff <= a_side_ff;
      end
   end

   assign in_stall   = !adv_a;
   assign out_valid  = b_valid_ff;
   assign out_tenths = BIN_W'(b_prod_ff[PROD_W-1:RECIP_SHIFT]);
   assign out_side   = b_side_ff;

endmodule
`default_nettype wire

// File: rtl/core/ssw_bcd.sv
// Pipelined binary to BCD conversion, a fixed number of shift steps per stage.
`timescale 1ns / 1ps
`default_nettype none
module ssw_bcd
   import ssw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire logic [BIN_W-1:0] in_bin,
   input  wire side_type         in_side,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output logic [BCD_W-1:0]      out_bcd,
   output side_type              out_side
);

   logic     valid_ff [DD_STAGES];
   logic     valid_in [DD_STAGES];
   dd_type   dd_ff    [DD_STAGES];
   side_type side_ff  [DD_STAGES];
   logic     adv      [DD_STAGES];
   dd_type   dd_next  [DD_STAGES];

   function automatic dd_type dd_run(input dd_type x);
      dd_type r;
      r = x;
      for (int s = 0; s < DD_STEPS; s++) begin
         for (int d = 0; d < BCD_DIGITS; d++) begin
            if (r.bcd[4*d +: 4] >= 4'd5) begin
               r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
            end
         end
         r = r << 1;
      end
      return r;
   endfunction

   always_comb begin
      for (int s = DD_STAGES - 1; s >= 0; s--) begin
         if (s == DD_STAGES - 1) begin
            adv[s] = !valid_ff[s] || !out_stall;
         end else begin
            adv[s] = !valid_ff[s] || adv[s+1];
         end
      end
      for (int s = 0; s < DD_STAGES; s++) begin
         if (s == 0) begin
            valid_in[s] = adv[s] ? in_valid : valid_ff[s];
            dd_next[s]  = dd_run(dd_type'{bcd: '0, bin: in_bin});
         end else begin
            valid_in[s] = adv[s] ? valid_ff[s-1] : valid_ff[s];
            dd_next[s]  = dd_run(dd_ff[s-1]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DD_STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DD_STAGES; s++) begin
         if (s == 0) begin
            if (adv[s] && in_valid) begin
               dd_ff[s]   <= dd_next[s];
               side_ff[s] <= in_side;
            end
         end else begin
            if (adv[s] && valid_ff[s-1]) begin
               dd_ff[s]   <= dd_next[s];
               side_ff[s] <= side_ff[s-1];
            end
         end
      end
   end

   assign in_stall  = !adv[0];
   assign out_valid = valid_ff[DD_STAGES-1];
   assign out_bcd   = dd_ff[DD_STAGES-1].bcd;
   assign out_side  = side_ff[DD_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/core/ssw_layout.sv
// Screen layout stage: places digits, sign, text and decimal points.
`timescale 1ns / 1ps
`default_nettype none
module ssw_layout
   import ssw_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_stall,
   input  wire logic [BCD_W-1:0] in_bcd,
   input  wire side_type         in_side,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output screen_type            out_screen
);

   logic                  valid_ff, valid_in;
   screen_type            screen_ff, screen_in;
   logic                  adv;
   logic [8*TEXT_LEN-1:0] txt;
   logic [BCD_DIGITS:0]   nz;
   logic [NUM_DIGITS-1:0] written;
   logic                  is_number;

   always_comb begin
      adv       = !valid_ff || !out_stall;
      valid_in  = adv ? in_valid : valid_ff;
      txt       = text_screen(in_side.mode);
      is_number = (in_side.mode == MODE_WEIGHT) || (in_side.mode == MODE_SETPOINT);

      // A digit above the tenths and ones is shown only if it or a higher one is nonzero.
      nz[BCD_DIGITS] = 1'b0;
      for (int p = BCD_DIGITS - 1; p >= 0; p--) begin
         nz[p] = nz[p+1] | (|in_bcd[4*p +: 4]);
      end
      for (int p = 0; p < NUM_DIGITS; p++) begin
         written[p] = (p < 2) || ((p < BCD_DIGITS) && nz[p]);
      end

      for (int p = 0; p < NUM_DIGITS; p++) begin
         screen_in.chars[p] = txt[8*(TEXT_LEN - NUM_DIGITS + p) +: 7];
         screen_in.dps[p]   = 1'b0;
         if (in_side.mode == MODE_CONNECTING) begin
            if ((NUM_DIGITS - 5 - p >= 0) && (NUM_DIGITS - 5 - p < 4) &&
                (NUM_DIGITS - 5 - p < int'(in_side.attempt))) begin
               screen_in.chars[p] = CH_DOT;
            end
         end
         if (is_number) begin
            if (written[p]) begin
               screen_in.chars[p] = CH_ZERO + 7'(in_bcd[4*p +: 4]);
               screen_in.dps[p]   = (p == 1);
            end else if (in_side.neg && (p > 0) && written[(p > 0) ? p - 1 : 0]) begin
               screen_in.chars[p] = CH_MINUS;
            end
         end
      end
      if (in_side.mode == MODE_WEIGHT) begin
         screen_in.chars[NUM_DIGITS-1] = CH_SPACE;
         screen_in.dps[NUM_DIGITS-1]   = in_side.stable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && in_valid) begin
         screen_ff <= screen_in;
      end
   end

   assign in_stall   = !adv;
   assign out_valid  = valid_ff;
   assign out_screen = screen_ff;

endmodule
`default_nettype wire

// File: rtl/core/ssw_serializer.sv
// Emits a finished screen one digit per transaction, with direction mapping.
`timescale 1ns / 1ps
`default_nettype none
module ssw_serializer
   import ssw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       right_to_left,
   input  wire logic       in_valid,
   output logic            in_stall,
   input  wire screen_type in_screen,
   output logic            out_valid,
   input  wire logic       out_stall,
   output logic [IDX_W-1:0] out_digit_index,
   output logic [6:0]      out_char_code,
   output logic            out_decimal_point,
   output logic            out_last
);

   logic             busy_ff, busy_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   screen_type       screen_ff;
   logic             last, emit_done, take;
   logic [IDX_W-1:0] lp;

   always_comb begin
      last      = (idx_ff == IDX_W'(NUM_DIGITS - 1));
      emit_done = busy_ff && !out_stall && last;
      take      = in_valid && (!busy_ff || emit_done);
      if (take) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (emit_done) begin
         busy_in = 1'b0;
         idx_in  = idx_ff;
      end else if (busy_ff && !out_stall) begin
         busy_in = 1'b1;
         idx_in  = idx_ff + 1'b1;
      end else begin
         busy_in = busy_ff;
         idx_in  = idx_ff;
      end
      lp = right_to_left ? idx_ff : IDX_W'(NUM_DIGITS - 1) - idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         screen_ff <= in_screen;
      end
   end

   assign in_stall          = busy_ff && !emit_done;
   assign out_valid         = busy_ff;
   assign out_digit_index   = idx_ff;
   assign out_char_code     = screen_ff.chars[lp];
   assign out_decimal_point = screen_ff.dps[lp];
   assign out_last          = last;

endmodule
`default_nettype wire

// File: rtl/core/seven_segment_weight_formatter.sv
// The first digit of a screen is presented once its request has passed the rounding,
// BCD and layout stages and been taken into the serializer, which emits one digit a cycle
// while the receiver does not stall and takes the next screen as the last digit leaves;
// the pipeline ahead of it holds up to seven further requests meanwhile.
// Reset: synchronous, active high; clears all valid bits and sets right_to_left to 1.
// There is no memory and no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_weight_formatter
   import ssw_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic               csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [3:0]         req_mode,
   input  wire logic signed [31:0] req_weight_mg,
   input  wire logic               req_stable,
   input  wire logic [3:0]         req_attempt,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [IDX_W-1:0]        rsp_digit_index,
   output logic [6:0]              rsp_char_code,
   output logic                    rsp_decimal_point,
   output logic                    rsp_last
);

   // Direction register. The user changes it only while the block is idle; the block does
   // not enforce it. The serializer reads it live to map a logical position to a digit.
   logic right_to_left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         right_to_left_ff <= 1'b1;
      end else if (csr_we) begin
         right_to_left_ff <= csr_wdata;
      end
   end

   // Sideband fields travel next to the number through every stage.
   side_type req_side;

   always_comb begin
      req_side.mode    = mode_type'(req_mode);
      req_side.neg     = req_weight_mg[31];
      req_side.stable  = req_stable;
      req_side.attempt = req_attempt;
   end

   // Stages 1 and 2: magnitude with saturation, half-up rounding offset, and
   // the divide by 100 as one reciprocal multiply.
   logic             rnd_valid, rnd_stall;
   logic [BIN_W-1:0] rnd_tenths;
   side_type         rnd_side;

   ssw_round u_round (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_weight_mg (req_weight_mg),
      .in_side      (req_side),
      .out_valid    (rnd_valid),
      .out_stall    (rnd_stall),
      .out_tenths   (rnd_tenths),
      .out_side     (rnd_side)
   );

   // Stages 3 to 6: binary to decimal digits, seven shift steps per stage.
   logic             bcd_valid, bcd_stall;
   logic [BCD_W-1:0] bcd_digits;
   side_type         bcd_side;

   ssw_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rnd_valid),
      .in_stall  (rnd_stall),
      .in_bin    (rnd_tenths),
      .in_side   (rnd_side),
      .out_valid (bcd_valid),
      .out_stall (bcd_stall),
      .out_bcd   (bcd_digits),
      .out_side  (bcd_side)
   );

   // Stage 7: the whole screen is assembled into one register.
   logic       lay_valid, lay_stall;
   screen_type lay_screen;

   ssw_layout u_layout (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (bcd_valid),
      .in_stall   (bcd_stall),
      .in_bcd     (bcd_digits),
      .in_side    (bcd_side),
      .out_valid  (lay_valid),
      .out_stall  (lay_stall),
      .out_screen (lay_screen)
   );

   // Stage 8: the serializer holds one screen and sends a digit per
   // transaction; it takes the next screen as the last digit leaves.
   ssw_serializer u_serializer (
      .clock             (clock),
      .reset             (reset),
      .right_to_left     (right_to_left_ff),
      .in_valid          (lay_valid),
      .in_stall          (lay_stall),
      .in_screen         (lay_screen),
      .out_valid         (rsp_valid),
      .out_stall         (rsp_stall),
      .out_digit_index   (rsp_digit_index),
      .out_char_code     (rsp_char_code),
      .out_decimal_point (rsp_decimal_point),
      .out_last          (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // A screen, once started, keeps presenting digits until its last one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("screen ended before its last digit");

   // Digits of one screen go out in order without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=>
         rsp_digit_index == IDX_W'($past(rsp_digit_index) + 1'b1))
      else $error("digit index skipped or repeated");

   // A screen that starts after no digit was presented begins at digit zero.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> rsp_digit_index == '0)
      else $error("screen did not start at digit zero");

   // Nothing is presented in the cycle after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the seven-segment weight formatter: directed screens, then random ones.
`timescale 1ns / 1ps
module testbench
   import ssw_pkg::*;
();

   localparam int LIMIT_CYCLES     = 200000;
   localparam int DRAIN_CYCLES     = 24;
   localparam int HOLD_CYCLES      = 300;
   localparam int RANDOM_PER_PHASE = 102;
   localparam int NUM_ROWS         = 25;

   // Mode codes that the block does not define; both must give a blank screen.
   localparam logic [3:0] MODE_UNUSED_LO = 4'd10;
   localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

   // One displayed digit as it should leave the block.
   typedef struct {
      logic [IDX_W-1:0] digit_index;
      logic [6:0]       char_code;
      logic             point;
      logic             last;
   } digit_type;

   // One row of the directed table. When typed is set, the screen is spelled out in text
   // (leftmost character in the top byte) and points (bit p for logical position p).
   // Otherwise the expected screen comes from the screen predictor.
   typedef struct {
      logic [3:0]            mode;
      logic [31:0]           weight_mg;
      logic                  stable;
      logic [3:0]            attempt;
      bit                    typed;
      logic [8*NUM_DIGITS-1:0] text;
      logic [NUM_DIGITS-1:0] points;
   } row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_we = 1'b0;
   logic               csr_wdata = 1'b0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [3:0]         req_mode = 4'd0;
   logic signed [31:0] req_weight_mg = 32'sd0;
   logic               req_stable = 1'b0;
   logic [3:0]         req_attempt = 4'd0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [IDX_W-1:0]   rsp_digit_index;
   logic [6:0]         rsp_char_code;
   logic               rsp_decimal_point;
   logic               rsp_last;

   // Digits still owed by the block, oldest first.
   digit_type expected_digits[$];
   digit_type want_digit;

   // Our copy of the direction register; the block resets it to 1.
   logic right_to_left = 1'b1;

   int  mismatches = 0;
   int  cycles = 0;
   int  burst_left;
   bit  offering = 1'b0;

   // Receiver state. The long hold-off is armed by the stimulus process and counted here.
   logic hold_armed = 1'b0;
   int   hold_count = 0;
   int   segment_left = 0;
   int   stall_pct = 0;

   // The directed screens. The first rows are simple enough to spell out by hand; the rest
   // cover rounding edges, negative zero, saturation and overflow and are predicted.
   row_type directed_rows [NUM_ROWS] = '{
      '{MODE_WEIGHT,     32'd0,       1'b0, 4'd0,  1'b1, "      00", 8'h02},
      '{MODE_WEIGHT,     32'd0,       1'b1, 4'd0,  1'b1, "      00", 8'h82},
      '{MODE_SETPOINT,   32'd0,       1'b0, 4'd0,  1'b1, "SP    00", 8'h02},
      '{MODE_ERROR,      32'd0,       1'b0, 4'd0,  1'b1, "Err     ", 8'h00},
      '{MODE_CAL_ZERO,   32'd0,       1'b0, 4'd0,  1'b1, "CAL0    ", 8'h00},
      '{MODE_CAL_SPAN,   32'd0,       1'b0, 4'd0,  1'b1, "SPAn    ", 8'h00},
      '{MODE_DONE,       32'd0,       1'b0, 4'd0,  1'b1, "donE    ", 8'h00},
      '{MODE_HOLD,       32'd0,       1'b0, 4'd0,  1'b1, "HoLd    ", 8'h00},
      '{MODE_STARTUP,    32'd0,       1'b0, 4'd0,  1'b1, "Coffee  ", 8'h00},
      '{MODE_CONNECTING, 32'd0,       1'b0, 4'd0,  1'b1, "Air     ", 8'h00},
      '{MODE_CONNECTING, 32'd0,       1'b0, 4'd4,  1'b1, "Air ....", 8'h00},
      '{MODE_CONNECTING, 32'd0,       1'b0, 4'd15, 1'b1, "Air ....", 8'h00},
      '{MODE_CONNECTED,  32'd0,       1'b0, 4'd0,  1'b1, "ConnECtd", 8'h00},
      '{MODE_UNUSED_LO,  32'd0,       1'b0, 4'd0,  1'b1, "        ", 8'h00},
      '{MODE_UNUSED_HI,  -32'sd1,     1'b1, 4'd15, 1'b1, "        ", 8'h00},
      '{MODE_WEIGHT,     -32'sd1,     1'b1, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_WEIGHT,     32'd49,      1'b0, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_WEIGHT,     32'd50,      1'b0, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_WEIGHT,     -32'sd50,    1'b0, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_WEIGHT,     MOST_POS,    1'b1, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_WEIGHT,     MOST_NEG,    1'b0, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_SETPOINT,   MOST_POS,    1'b0, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_SETPOINT,   MOST_NEG,    1'b1, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_SETPOINT,   -32'sd99999, 1'b0, 4'd0,  1'b0, 64'd0, 8'h00},
      '{MODE_CONNECTING, 32'd0,       1'b0, 4'd2,  1'b0, 64'd0, 8'h00}
   };

   seven_segment_weight_formatter uut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_weight_mg     (req_weight_mg),
      .req_stable        (req_stable),
      .req_attempt       (req_attempt),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_digit_index   (rsp_digit_index),
      .rsp_char_code     (rsp_char_code),
      .rsp_decimal_point (rsp_decimal_point),
      .rsp_last          (rsp_last)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Screen predictor. A screen is built in logical positions, 0 being the rightmost digit;
   // a later write to a position replaces whatever was there.
   // ---------------------------------------------------------------------------------------

   function automatic void place(inout screen_type s, input int pos, input logic [6:0] ch,
                                 input logic dp);
      if (pos >= 0 && pos < NUM_DIGITS) begin
         s.chars[pos] = ch;
         s.dps[pos]   = dp;
      end
   endfunction

   // Text starts at the leftmost digit and runs rightward.
   function automatic void place_text(inout screen_type s, input string t);
      for (int k = 0; k < t.len(); k++) begin
         place(s, NUM_DIGITS - 1 - k, 7'(t[k]), 1'b0);
      end
   endfunction

   // Magnitude rounded half-up to tenths of a gram, right-aligned with the point on the
   // ones digit. The two lowest digits are always written, so zero shows as 0.0. Digits
   // that do not fit are lost, and the minus sign goes only into a free position.
   function automatic void place_number(inout screen_type s, input logic [31:0] raw);
      logic        neg;
      logic [31:0] mag;
      logic [31:0] tenths;
      int          pos;
      neg = raw[31];
      if (raw == MOST_NEG) begin
         mag = MOST_POS;
      end else if (neg) begin
         mag = -raw;
      end else begin
         mag = raw;
      end
      tenths = (mag + 32'd50) / 32'd100;
      place(s, 0, CH_ZERO + 7'(tenths % 32'd10), 1'b0);
      tenths = tenths / 32'd10;
      place(s, 1, CH_ZERO + 7'(tenths % 32'd10), 1'b1);
      tenths = tenths / 32'd10;
      pos = 2;
      while (tenths != 32'd0 && pos < NUM_DIGITS) begin
         place(s, pos, CH_ZERO + 7'(tenths % 32'd10), 1'b0);
         tenths = tenths / 32'd10;
         pos++;
      end
      if (neg && pos < NUM_DIGITS) begin
         place(s, pos, CH_MINUS, 1'b0);
      end
   endfunction

   function automatic screen_type predict_screen(input logic [3:0] mode,
                                                 input logic [31:0] weight_mg,
                                                 input logic stable,
                                                 input logic [3:0] attempt);
      screen_type s;
      s.chars = {NUM_DIGITS{CH_SPACE}};
      s.dps   = '0;
      case (mode)
         MODE_WEIGHT: begin
            // The leftmost digit is blanked and shows the stable mark on its point.
            place_number(s, weight_mg);
            place(s, NUM_DIGITS - 1, CH_SPACE, stable);
         end
         MODE_SETPOINT: begin
            place_text(s, "SP");
            place_number(s, weight_mg);
         end
         MODE_ERROR:      place_text(s, "Err");
         MODE_CAL_ZERO:   place_text(s, "CAL0");
         MODE_CAL_SPAN:   place_text(s, "SPAn");
         MODE_DONE:       place_text(s, "donE");
         MODE_HOLD:       place_text(s, "HoLd");
         MODE_STARTUP:    place_text(s, "Coffee");
         MODE_CONNECTING: begin
            // One dot per attempt, at most four, after "Air ".
            place_text(s, "Air ");
            for (int k = 0; k < 4 && k < int'(attempt); k++) begin
               place(s, NUM_DIGITS - 5 - k, CH_DOT, 1'b0);
            end
         end
         MODE_CONNECTED:  place_text(s, "ConnECtd");
         default: begin
         end
      endcase
      return s;
   endfunction

   // Turns a logical screen into the physical digit sequence, 0 upward, under the current
   // direction setting, and queues it.
   function automatic void queue_screen(input screen_type s);
      digit_type d;
      int        lp;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         lp            = right_to_left ? i : NUM_DIGITS - 1 - i;
         d.digit_index = IDX_W'(i);
         d.char_code   = s.chars[lp];
         d.point       = s.dps[lp];
         d.last        = (i == NUM_DIGITS - 1);
         expected_digits.push_back(d);
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("cycle %0d: %s", cycles, msg);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Request side. Each transaction is offered until accepted; the sender runs in bursts,
   // and valid is only dropped for the gap between two bursts and while waiting for idle.
   // ---------------------------------------------------------------------------------------

   task automatic send_screen(input logic [3:0] mode, input logic [31:0] weight_mg,
                              input logic stable, input logic [3:0] attempt,
                              input screen_type want);
      int gap;
      req_valid     <= 1'b1;
      req_mode      <= mode;
      req_weight_mg <= weight_mg;
      req_stable    <= stable;
      req_attempt   <= attempt;
      offering = 1'b1;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      // The direction only changes while the block is idle, so it is safe to map now.
      queue_screen(want);
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         req_valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 10);
      end
   endtask

   // Drops valid unless the gap logic already did, then waits for every expected digit and
   // lets the pipeline settle.
   task automatic wait_idle;
      if (offering) begin
         req_valid <= 1'b0;
         offering = 1'b0;
      end
      while (expected_digits.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The direction register is written only while nothing is in flight.
   task automatic set_direction(input logic value);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      right_to_left = value;
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus: reset, the directed table, then three random phases that switch the
   // direction between them. The receiver's long hold-off is armed in the middle phase.
   // ---------------------------------------------------------------------------------------

   initial begin
      screen_type  s;
      logic [3:0]  mode;
      logic [31:0] weight;
      logic        stable_bit;
      logic [3:0]  attempt_count;
      int          kind;
      burst_left = $urandom_range(1, 10);
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r]) begin
         if (directed_rows[r].typed) begin
            for (int p = 0; p < NUM_DIGITS; p++) begin
               s.chars[p] = directed_rows[r].text[8*p +: 7];
            end
            s.dps = directed_rows[r].points;
         end else begin
            s = predict_screen(directed_rows[r].mode, directed_rows[r].weight_mg,
                               directed_rows[r].stable, directed_rows[r].attempt);
         end
         send_screen(directed_rows[r].mode, directed_rows[r].weight_mg,
                     directed_rows[r].stable, directed_rows[r].attempt, s);
      end

      for (int phase = 0; phase < 3; phase++) begin
         set_direction(phase == 1);
         if (phase == 1) begin
            hold_armed <= 1'b1;
         end
         repeat (RANDOM_PER_PHASE) begin
            // Mostly number screens, since that is where the arithmetic lives.
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               mode = MODE_WEIGHT;
            end else if (kind < 70) begin
               mode = MODE_SETPOINT;
            end else if (kind < 93) begin
               mode = 4'($urandom_range(MODE_ERROR, MODE_CONNECTED));
            end else begin
               mode = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            end
            // Values from several ranges: raw bits, near zero (negative zero lives there),
            // right on a rounding edge, the extremes, and more digits than fit.
            kind = $urandom_range(0, 5);
            case (kind)
               0: weight = $urandom;
               1: weight = $urandom_range(0, ($urandom_range(0, 1) == 1) ? 149 : 20000);
               2: weight = $urandom_range(0, 999999) * 100 + (($urandom_range(0, 1) == 1) ? 49 : 50);
               3: begin
                  case ($urandom_range(0, 3))
                     0:       weight = MOST_NEG;
                     1:       weight = MOST_POS;
                     2:       weight = 32'd0;
                     default: weight = 32'd50;
                  endcase
               end
               4: weight = $urandom_range(0, 99999999);
               default: weight = $urandom_range(1000000000, MOST_POS);
            endcase
            if (kind != 0 && $urandom_range(0, 1) == 1) begin
               weight = -weight;
            end
            stable_bit    = 1'($urandom_range(0, 1));
            attempt_count = 4'($urandom_range(0, 15));
            s = predict_screen(mode, weight, stable_bit, attempt_count);
            send_screen(mode, weight, stable_bit, attempt_count, s);
         end
      end

      wait_idle();
      if (mismatches == 0 && expected_digits.size() == 0) begin
         $display("** seven_segment_weight_formatter: PASSED **");
      end else begin
         $display("** seven_segment_weight_formatter: FAILED **");
      end
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Response side. The receiver stalls in segments of random length, each with its own
   // stall rate, some with no stalls at all. Once armed, it holds off for a long stretch
   // so that the pipeline fills and the block pushes back on its request side.
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (hold_armed && hold_count < HOLD_CYCLES) begin
         hold_count++;
         rsp_stall <= 1'b1;
      end else begin
         if (segment_left == 0) begin
            segment_left = $urandom_range(4, 60);
            case ($urandom_range(0, 4))
               0, 1:    stall_pct = 0;
               2:       stall_pct = 20;
               3:       stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         segment_left--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Every accepted digit is matched against the oldest expected one, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_digits.size() == 0) begin
            report_mismatch($sformatf("digit %0d arrived with no screen pending",
                                      rsp_digit_index));
         end else begin
            want_digit = expected_digits.pop_front();
            if (rsp_digit_index !== want_digit.digit_index) begin
               report_mismatch($sformatf("digit_index got %0d, expected %0d",
                                         rsp_digit_index, want_digit.digit_index));
            end
            if (rsp_char_code !== want_digit.char_code) begin
               report_mismatch($sformatf("digit %0d char_code got %0d, expected %0d",
                                         want_digit.digit_index, rsp_char_code,
                                         want_digit.char_code));
            end
            if (rsp_decimal_point !== want_digit.point) begin
               report_mismatch($sformatf("digit %0d decimal_point got %b, expected %b",
                                         want_digit.digit_index, rsp_decimal_point,
                                         want_digit.point));
            end
            if (rsp_last !== want_digit.last) begin
               report_mismatch($sformatf("digit %0d last got %b, expected %b",
                                         want_digit.digit_index, rsp_last, want_digit.last));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT_CYCLES) begin
         $display("** seven_segment_weight_formatter: FAILED **");
         $finish;
      end
   end

endmodule

// File: filelist.f
rtl/core/ssw_pkg.sv
rtl/core/ssw_round.sv
rtl/core/ssw_bcd.sv
rtl/core/ssw_layout.sv
rtl/core/ssw_serializer.sv
rtl/core/seven_segment_weight_formatter.sv
verif/testbench.sv
